@@ design/mtrb_pkg.sv @@
// Shared types and constants of the MT19937 bounded random value generator.
package mtrb_pkg;

    // Generator geometry
    localparam int MT_N = 624;
    localparam int MT_M = 397;
    localparam int ADDR_W = 10;     // holds 0..MT_N, the read position included
    localparam int BITS_W = 7;      // bit length of a 64-bit bound, 0..64

    // Generator constants
    localparam logic [31:0] MT_MATRIX   = 32'h9908_B0DF;
    localparam logic [31:0] MT_HIGH_BIT = 32'h8000_0000;
    localparam logic [31:0] MT_LOW_BITS = 32'h7FFF_FFFF;
    localparam logic [31:0] TEMPER_B    = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C    = 32'hEFC6_0000;
    localparam logic [31:0] INIT_SEED   = 32'd19650218;
    localparam logic [31:0] INIT_MULT   = 32'd1812433253;
    localparam logic [31:0] MIX1_MULT   = 32'd1664525;
    localparam logic [31:0] MIX2_MULT   = 32'd1566083941;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Command codes carried in the mode field
    localparam logic MODE_RESEED = 1'b0;
    localparam logic MODE_DRAW   = 1'b1;

    // Status codes
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_ZERO_BOUND = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [63:0] upper_bound;
    } t_in;

    typedef struct packed {
        logic [63:0] random_value;
        logic        status;
    } t_out;

    // Classified command, as queued between front and back
    typedef struct packed {
        logic              mode;
        logic              zero;
        logic [BITS_W-1:0] bits;
        logic [63:0]       bound;
    } t_task;

    // State memory request from the back end
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [31:0]       wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_ram_req;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SEED_INIT,
        BK_SEED_RD,
        BK_SEED_WR,
        BK_SEED_WRAP,
        BK_SEED_FIN,
        BK_FETCH,
        BK_TW_PRE,
        BK_TW_LOAD,
        BK_TW_RD,
        BK_TW_WR,
        BK_TEMPER,
        BK_CHECK,
        BK_DONE
    } t_bstate;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_MIX1,
        PH_MIX2,
        PH_END
    } t_phase;

endpackage

@@ design/mtrb_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
module mtrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ design/mtrb_front.sv @@
// Front end: accepts commands and classifies them by bound bit length.
module mtrb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mtrb_pkg::t_in  i_in_data,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output mtrb_pkg::t_task o_push_data
);
    import mtrb_pkg::*;

    localparam int GROUPS = 8;

    logic       r_hold_valid;
    t_in        r_hold;
    logic [3:0] r_len [GROUPS];
    logic [BITS_W-1:0] bits;

    // Bit length of one byte, 0..8
    function automatic logic [3:0] byte_len(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) n = 4'(k + 1);
        end
        return n;
    endfunction

    assign o_in_ready   = !r_hold_valid || i_push_ready;
    assign o_push_valid = r_hold_valid;

    // Hold the transaction with its per-byte bit lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_hold_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_hold_valid <= 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            r_hold <= i_in_data;
            for (int g = 0; g < GROUPS; g++) begin
                r_len[g] <= byte_len(i_in_data.upper_bound[8*g +: 8]);
            end
        end
    end

    // Pick the highest nonzero byte
    always_comb begin
        bits = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (r_len[g] != 4'd0) bits = BITS_W'(8 * g) + BITS_W'(r_len[g]);
        end
    end

    assign o_push_data.mode  = r_hold.mode;
    assign o_push_data.bound = r_hold.upper_bound;
    assign o_push_data.bits  = bits;
    assign o_push_data.zero  = (bits == '0);

endmodule

@@ design/mtrb_queue.sv @@
// Short FIFO of classified commands between front and back.
module mtrb_queue #(
    parameter int DEPTH = mtrb_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  mtrb_pkg::t_task i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output mtrb_pkg::t_task o_pop_data
);
    import mtrb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_task             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_push_data;
    end

endmodule

@@ design/mtrb_back.sv @@
// Back end: seeding, regeneration, tempering and rejection draws on the state RAM.
module mtrb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  mtrb_pkg::t_task    i_pop_data,
    input  logic [63:0]        i_seed,
    output mtrb_pkg::t_ram_req o_ram,
    input  logic [31:0]        i_rdata_a,
    input  logic [31:0]        i_rdata_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mtrb_pkg::t_out     o_out_data
);
    import mtrb_pkg::*;

    localparam logic [ADDR_W-1:0] N_IDX    = ADDR_W'(MT_N);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(MT_N - 1);
    localparam logic [ADDR_W-1:0] SPLIT    = ADDR_W'(MT_N - MT_M);
    localparam logic [ADDR_W-1:0] M_OFS    = ADDR_W'(MT_M);
    localparam logic [ADDR_W-1:0] ONE_IDX  = ADDR_W'(1);

    t_bstate            r_state, n_state;
    t_phase             r_phase;
    logic [ADDR_W-1:0]  r_i;
    logic               r_j;
    logic [ADDR_W-1:0]  r_cnt;
    logic [31:0]        r_p;
    logic [31:0]        r_prod;
    logic [63:0]        r_key;
    logic               r_cmd;
    logic [ADDR_W-1:0]  r_pos;
    logic [ADDR_W-1:0]  r_n;
    logic [31:0]        r_cur;
    logic [63:0]        r_bound;
    logic [BITS_W-1:0]  r_bits;
    logic               r_wsel;
    logic [63:0]        r_val;
    t_out               r_res;
    logic               r_out_valid;
    t_out               r_out;

    logic [31:0]        mix;
    logic [31:0]        mulc;
    logic [31:0]        key_word;
    logic [31:0]        seed_new;
    logic [31:0]        twist_new;
    logic [31:0]        tempered;
    logic [31:0]        chunk;
    logic [4:0]         sh;
    logic [ADDR_W-1:0]  tw_a_addr;
    logic [ADDR_W-1:0]  tw_b_addr;
    logic               seed_last;
    logic               seed_wrap;
    logic               load_out;

    function automatic logic [31:0] temper(input logic [31:0] y);
        logic [31:0] t;
        t = y ^ (y >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        return t ^ (t >> 18);
    endfunction

    function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        logic [31:0] y;
        y = (a & MT_HIGH_BIT) | (b & MT_LOW_BITS);
        return c ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
    endfunction

    // Seeding datapath
    assign mix      = r_p ^ (r_p >> 30);
    assign key_word = r_j ? r_key[63:32] : r_key[31:0];
    always_comb begin
        case (r_phase)
            PH_INIT: mulc = INIT_MULT;
            PH_MIX1: mulc = MIX1_MULT;
            default: mulc = MIX2_MULT;
        endcase
    end
    always_comb begin
        case (r_phase)
            PH_INIT: seed_new = r_prod + 32'(r_i);
            PH_MIX1: seed_new = (i_rdata_a ^ r_prod) + key_word + 32'(r_j);
            default: seed_new = (i_rdata_a ^ r_prod) - 32'(r_i);
        endcase
    end
    assign seed_last = (r_cnt == '0);
    assign seed_wrap = (r_i == LAST_IDX);

    // Regeneration and draw datapath
    assign tw_a_addr = (r_n == LAST_IDX) ? '0 : r_n + 1'b1;
    assign tw_b_addr = (r_n < SPLIT) ? r_n + M_OFS : r_n - SPLIT;
    assign twist_new = twist(r_cur, i_rdata_a, i_rdata_b);
    assign tempered  = temper(i_rdata_a);
    assign sh        = 5'(5'd0 - r_bits[4:0]);
    assign chunk     = tempered >> sh;

    assign o_pop_ready = (r_state == BK_IDLE);
    assign load_out    = (r_state == BK_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_pop_valid) begin
                    if (i_pop_data.mode == MODE_RESEED) n_state = BK_SEED_INIT;
                    else if (i_pop_data.zero)           n_state = BK_DONE;
                    else                                n_state = BK_FETCH;
                end
            end
            BK_SEED_INIT: n_state = BK_SEED_RD;
            BK_SEED_RD:   n_state = BK_SEED_WR;
            BK_SEED_WR: begin
                if (r_phase == PH_INIT)                  n_state = BK_SEED_RD;
                else if (seed_wrap)                      n_state = BK_SEED_WRAP;
                else if (seed_last && r_phase == PH_MIX2) n_state = BK_SEED_FIN;
                else                                     n_state = BK_SEED_RD;
            end
            BK_SEED_WRAP: n_state = (r_phase == PH_END) ? BK_SEED_FIN : BK_SEED_RD;
            BK_SEED_FIN:  n_state = r_cmd ? BK_DONE : BK_IDLE;
            BK_FETCH:     n_state = (r_pos >= N_IDX) ? BK_TW_PRE : BK_TEMPER;
            BK_TW_PRE:    n_state = BK_TW_LOAD;
            BK_TW_LOAD:   n_state = BK_TW_RD;
            BK_TW_RD:     n_state = BK_TW_WR;
            BK_TW_WR:     n_state = (r_n == LAST_IDX) ? BK_FETCH : BK_TW_RD;
            BK_TEMPER: begin
                if (r_bits <= BITS_W'(32) || r_wsel) n_state = BK_CHECK;
                else                                 n_state = BK_FETCH;
            end
            BK_CHECK:     n_state = (r_val < r_bound) ? BK_DONE : BK_FETCH;
            BK_DONE:      n_state = load_out ? BK_IDLE : BK_DONE;
            default:      n_state = BK_IDLE;
        endcase
    end

    // RAM requests
    always_comb begin
        o_ram.we      = 1'b0;
        o_ram.waddr   = '0;
        o_ram.wdata   = '0;
        o_ram.raddr_a = '0;
        o_ram.raddr_b = '0;
        case (r_state)
            BK_SEED_INIT: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = INIT_SEED;
            end
            BK_SEED_RD: o_ram.raddr_a = r_i;
            BK_SEED_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_i;
                o_ram.wdata = seed_new;
            end
            BK_SEED_WRAP: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = r_p;
            end
            BK_SEED_FIN: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = MT_HIGH_BIT;
            end
            BK_FETCH: o_ram.raddr_a = (r_pos < N_IDX) ? r_pos : '0;
            BK_TW_RD: begin
                o_ram.raddr_a = tw_a_addr;
                o_ram.raddr_b = tw_b_addr;
            end
            BK_TW_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_n;
                o_ram.wdata = twist_new;
            end
            default: o_ram.we = 1'b0;
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_SEED_INIT;
            r_key       <= '0;
            r_cmd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)         r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (r_state == BK_IDLE && i_pop_valid && i_pop_data.mode == MODE_RESEED) begin
                r_key <= i_seed;
                r_cmd <= 1'b1;
            end
        end
    end

    // Datapath registers; the read position starts at the end of the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= N_IDX;
        end else begin
            if (load_out) r_out <= r_res;
            case (r_state)
                BK_IDLE: begin
                    r_bound <= i_pop_data.bound;
                    r_bits  <= i_pop_data.bits;
                    r_wsel  <= 1'b0;
                    r_res.random_value <= '0;
                    r_res.status <= (i_pop_data.mode == MODE_DRAW && i_pop_data.zero)
                                    ? STATUS_ZERO_BOUND : STATUS_OK;
                end
                BK_SEED_INIT: begin
                    r_p     <= INIT_SEED;
                    r_i     <= ONE_IDX;
                    r_phase <= PH_INIT;
                end
                BK_SEED_RD: r_prod <= mix * mulc;
                BK_SEED_WR: begin
                    if (r_phase == PH_INIT) begin
                        if (seed_wrap) begin
                            r_phase <= PH_MIX1;
                            r_i     <= ONE_IDX;
                            r_j     <= 1'b0;
                            r_cnt   <= LAST_IDX;
                            r_p     <= INIT_SEED;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_p <= seed_new;
                        end
                    end else begin
                        r_p <= seed_new;
                        r_j <= (r_key[63:32] != '0) ? !r_j : 1'b0;
                        r_i <= seed_wrap ? ONE_IDX : r_i + 1'b1;
                        if (!seed_last) begin
                            r_cnt <= r_cnt - 1'b1;
                        end else if (r_phase == PH_MIX1) begin
                            r_phase <= PH_MIX2;
                            r_cnt   <= ADDR_W'(MT_N - 2);
                        end else begin
                            r_phase <= PH_END;
                        end
                    end
                end
                BK_SEED_FIN: begin
                    r_pos <= N_IDX;
                    r_res.random_value <= '0;
                    r_res.status       <= STATUS_OK;
                end
                BK_TW_PRE:  r_n   <= '0;
                BK_TW_LOAD: r_cur <= i_rdata_a;
                BK_TW_WR: begin
                    r_cur <= i_rdata_a;
                    r_n   <= r_n + 1'b1;
                    if (r_n == LAST_IDX) r_pos <= '0;
                end
                BK_TEMPER: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_bits <= BITS_W'(32)) begin
                        r_val <= {32'd0, chunk};
                    end else if (!r_wsel) begin
                        r_val[31:0] <= tempered;
                        r_wsel      <= 1'b1;
                    end else begin
                        r_val[63:32] <= chunk;
                    end
                end
                BK_CHECK: begin
                    r_wsel <= 1'b0;
                    r_res.random_value <= r_val;
                    r_res.status       <= STATUS_OK;
                end
                default: r_wsel <= r_wsel;
            endcase
        end
    end

    // Read position never runs past the end of the state
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= N_IDX)
        else $error("read position beyond state size");

    // State writes stay inside the word store
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (o_ram.waddr < N_IDX))
        else $error("state write out of range");

    // Tempering uses the word read in the fetch cycle
    a_temper_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_TEMPER) |-> ($past(r_state) == BK_FETCH))
        else $error("tempering without a preceding fetch");

endmodule

@@ design/mt19937_rand_below_top.sv @@
// Top level of the MT19937 generator with reseed and bounded draws.
//
// Channels: an input channel (i_in_valid/o_in_ready, i_in_data) takes commands,
// an output channel (o_out_valid/i_out_ready, o_out_data) returns one result per
// command, and a configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_data)
// writes the 64-bit seed used by the next reseed command.
// A draw of up to 32 bits fetches, tempers and compares one word; a draw of more
// than 32 bits fetches and tempers a second word first, and every rejected draw
// repeats the fetch, temper and compare steps. Once per 624 words the state is
// regenerated in place, one word at a time, through the single state RAM with
// one write and two read ports.
// A reseed makes three passes over the 624-word RAM, with a read-modify-write
// of each state word.
// After reset the block runs the same seeding sequence with seed 0; commands
// accepted meanwhile wait in the front queue.
// When the receiver stalls, the result holds in the output register, the back
// end holds the next result, and the front keeps accepting until the queue fills.
module mt19937_rand_below_top #(
    parameter int QUEUE_DEPTH = mtrb_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mtrb_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mtrb_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [63:0]    i_cfg_data
);
    import mtrb_pkg::*;

    logic        seed_write;
    logic [63:0] r_seed_value;
    logic        push_valid;
    logic        push_ready;
    t_task       push_data;
    logic        pop_valid;
    logic        pop_ready;
    t_task       pop_data;
    t_ram_req    ram_req;
    logic [31:0] rdata_a;
    logic [31:0] rdata_b;

    assign o_cfg_ready = 1'b1;
    assign seed_write  = i_cfg_valid && o_cfg_ready;

    // Hold the seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_value <= '0;
        end else if (seed_write) begin
            r_seed_value <= i_cfg_data;
        end
    end

    mtrb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    mtrb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    mtrb_ram #(
        .WIDTH (32),
        .DEPTH (MT_N)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_req.we),
        .i_waddr   (ram_req.waddr),
        .i_wdata   (ram_req.wdata),
        .i_raddr_a (ram_req.raddr_a),
        .i_raddr_b (ram_req.raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    mtrb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .i_seed      (r_seed_value),
        .o_ram       (ram_req),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sim/mtrb_checker.sv @@
// Checker for the MT19937 bounded random generator: predicts each result and compares.
module mtrb_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  mtrb_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  mtrb_pkg::t_out i_out_data,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [63:0]    i_cfg_data,
    output int             o_errors,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mtrb_pkg::*;

    // Generator constants, kept apart from the design's own copies
    localparam int          N_WORDS    = 624;
    localparam int          TAP_OFFSET = 397;
    localparam logic [31:0] TWIST_XOR  = 32'h9908_B0DF;
    localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
    localparam logic [31:0] LOWER_MASK = 32'h7FFF_FFFF;
    localparam logic [31:0] TEMPER_1   = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_2   = 32'hEFC6_0000;
    localparam logic [31:0] FILL_START = 32'd19650218;
    localparam logic [31:0] FILL_MULT  = 32'd1812433253;
    localparam logic [31:0] KEY_MULT   = 32'd1664525;
    localparam logic [31:0] FOLD_MULT  = 32'd1566083941;

    logic [31:0] state_words [N_WORDS];
    int unsigned read_idx;
    logic [63:0] seed_reg;
    t_out        gen_results_q [$];
    t_out        want;
    int          mismatch_count = 0;
    int          result_count = 0;

    assign o_errors = mismatch_count;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Rebuild the word array from a 64-bit seed, one or two key words
    function automatic void reseed_state(input logic [63:0] seed);
        logic [31:0] key [2];
        int unsigned key_len;
        int unsigned i;
        int unsigned j;
        int unsigned k;
        logic [31:0] p;
        key[0] = seed[31:0];
        key[1] = seed[63:32];
        key_len = (key[1] != 32'd0) ? 2 : 1;
        state_words[0] = FILL_START;
        for (i = 1; i < N_WORDS; i++) begin
            p = state_words[i-1];
            state_words[i] = FILL_MULT * (p ^ (p >> 30)) + i;
        end
        i = 1;
        j = 0;
        for (k = N_WORDS; k > 0; k--) begin
            p = state_words[i-1];
            state_words[i] = (state_words[i] ^ ((p ^ (p >> 30)) * KEY_MULT)) + key[j] + j;
            i++;
            j++;
            if (i >= N_WORDS) begin
                state_words[0] = state_words[N_WORDS-1];
                i = 1;
            end
            if (j >= key_len)
                j = 0;
        end
        for (k = N_WORDS - 1; k > 0; k--) begin
            p = state_words[i-1];
            state_words[i] = (state_words[i] ^ ((p ^ (p >> 30)) * FOLD_MULT)) - i;
            i++;
            if (i >= N_WORDS) begin
                state_words[0] = state_words[N_WORDS-1];
                i = 1;
            end
        end
        state_words[0] = UPPER_MASK;
        read_idx = N_WORDS;
    endfunction

    function automatic logic [31:0] twist_word(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c);
        logic [31:0] y;
        y = (a & UPPER_MASK) | (b & LOWER_MASK);
        return c ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
    endfunction

    // Next tempered word; regenerate all words once the array is used up
    function automatic logic [31:0] tempered_word();
        int unsigned n;
        logic [31:0] y;
        if (read_idx >= N_WORDS) begin
            for (n = 0; n < N_WORDS - TAP_OFFSET; n++)
                state_words[n] = twist_word(state_words[n], state_words[n+1],
                                            state_words[n+TAP_OFFSET]);
            for (; n < N_WORDS - 1; n++)
                state_words[n] = twist_word(state_words[n], state_words[n+1],
                                            state_words[n+TAP_OFFSET-N_WORDS]);
            state_words[N_WORDS-1] = twist_word(state_words[N_WORDS-1], state_words[0],
                                                state_words[TAP_OFFSET-1]);
            read_idx = 0;
        end
        y = state_words[read_idx];
        read_idx++;
        y ^= y >> 11;
        y ^= (y << 7) & TEMPER_1;
        y ^= (y << 15) & TEMPER_2;
        y ^= y >> 18;
        return y;
    endfunction

    // Assemble nbits random bits, low word first, top bits of the last word
    function automatic logic [63:0] gather_bits(input int unsigned nbits);
        logic [63:0] acc;
        logic [31:0] w;
        int unsigned left;
        int unsigned shift;
        int unsigned chunk;
        if (nbits <= 32)
            return 64'(tempered_word() >> (32 - nbits));
        acc = '0;
        left = nbits;
        shift = 0;
        while (left > 0) begin
            chunk = (left < 32) ? left : 32;
            w = tempered_word();
            if (chunk < 32)
                w = w >> (32 - chunk);
            acc |= 64'(w) << shift;
            left -= chunk;
            shift += chunk;
        end
        return acc;
    endfunction

    function automatic int unsigned bound_bits(input logic [63:0] v);
        int unsigned n;
        n = 0;
        for (int b = 0; b < 64; b++)
            if (v[b])
                n = b + 1;
        return n;
    endfunction

    // Work out the result of one command and advance the generator copy
    function automatic t_out generate_result(input t_in cmd);
        t_out r;
        int unsigned nbits;
        logic [63:0] value;
        r.random_value = '0;
        r.status = STATUS_OK;
        if (cmd.mode == MODE_RESEED) begin
            reseed_state(seed_reg);
        end else if (cmd.upper_bound == 64'd0) begin
            r.status = STATUS_ZERO_BOUND;
        end else begin
            nbits = bound_bits(cmd.upper_bound);
            value = gather_bits(nbits);
            while (value >= cmd.upper_bound)
                value = gather_bits(nbits);
            r.random_value = value;
        end
        return r;
    endfunction

    // Compare results first, then take config writes and new commands
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_reg = '0;
            reseed_state(64'd0);
            gen_results_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (gen_results_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no command pending",
                                              result_count));
                end else begin
                    want = gen_results_q.pop_front();
                    if (i_out_data.random_value !== want.random_value)
                        report_mismatch($sformatf("result %0d value %h, expected %h",
                                                  result_count, i_out_data.random_value,
                                                  want.random_value));
                    if (i_out_data.status !== want.status)
                        report_mismatch($sformatf("result %0d status %b, expected %b",
                                                  result_count, i_out_data.status,
                                                  want.status));
                end
                result_count++;
            end
            if (i_cfg_valid && i_cfg_ready)
                seed_reg = i_cfg_data;
            if (i_in_valid && i_in_ready)
                gen_results_q.push_back(generate_result(i_in_data));
        end
        o_pending <= gen_results_q.size();
    end

endmodule

@@ sim/tb.sv @@
// Testbench top: drives commands, seed writes and result backpressure, gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mtrb_pkg::*;

    localparam int TOTAL_CMDS  = 1450;
    localparam int QUIET_LIMIT = 40000;
    localparam int TAIL_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;
    int          errors;
    int          pending;
    int          quiet_cycles = 0;
    int          cmds_sent = 0;
    bit          no_gaps = 1'b0;

    mt19937_rand_below_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    mtrb_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side: stall a random number of cycles before each transaction, unless no_gaps is set
    initial begin
        int stall;
        out_ready = 1'b0;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Send one command after a random gap, or none when no_gaps is set; drop valid once it is taken
    task automatic send_cmd(input logic mode, input logic [63:0] bound);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.mode = mode;
        in_data.upper_bound = bound;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
        cmds_sent++;
    endtask

    task automatic write_seed(input logic [63:0] seed);
        cfg_data = seed;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
    endtask

    // Bound with a random bit length, plus zero, all ones and powers of two
    function automatic logic [63:0] rand_bound();
        int unsigned pick;
        int unsigned len;
        logic [63:0] raw;
        logic [63:0] mask;
        pick = $urandom_range(0, 99);
        raw = {$urandom, $urandom};
        if (pick < 3)
            return 64'd0;
        if (pick < 5)
            return '1;
        if (pick < 9)
            return 64'd1 << $urandom_range(0, 63);
        len = $urandom_range(1, 64);
        mask = (len == 64) ? '1 : ((64'd1 << len) - 64'd1);
        return (raw & mask) | (64'd1 << (len - 1));
    endfunction

    function automatic logic [63:0] rand_seed();
        case ($urandom_range(0, 4))
            0: return 64'd0;
            1: return '1;
            2: return {32'd0, $urandom};
            3: return {$urandom | 32'd1, 32'd0};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int seg_len;
        logic mode;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Draws from the power-up state: bound extremes, word boundaries, zero bound; then a reseed and a draw
        send_cmd(MODE_DRAW, 64'd1);
        send_cmd(MODE_DRAW, 64'd2);
        send_cmd(MODE_DRAW, 64'd3);
        send_cmd(MODE_DRAW, 64'd0);
        send_cmd(MODE_DRAW, 64'h0000_0000_8000_0000);
        send_cmd(MODE_DRAW, 64'h0000_0000_FFFF_FFFF);
        send_cmd(MODE_DRAW, 64'h0000_0001_0000_0000);
        send_cmd(MODE_DRAW, 64'h0000_0001_0000_0001);
        send_cmd(MODE_DRAW, '1);
        send_cmd(MODE_DRAW, 64'h8000_0000_0000_0000);
        send_cmd(MODE_DRAW, 64'd0);
        send_cmd(MODE_RESEED, '1);
        send_cmd(MODE_DRAW, 64'h0000_0000_7FFF_FFFF);

        // Seed write alone must not disturb the generator until a reseed
        drain();
        write_seed('1);
        send_cmd(MODE_DRAW, 64'd100);
        send_cmd(MODE_RESEED, 64'd0);
        send_cmd(MODE_DRAW, '1);
        send_cmd(MODE_DRAW, 64'h0000_0000_FFFF_FFFF);

        // One-word key, two-word key with empty low half, back to zero
        drain();
        write_seed(64'h0000_0000_DEAD_BEEF);
        send_cmd(MODE_RESEED, 64'd5);
        send_cmd(MODE_DRAW, 64'd10);
        drain();
        write_seed(64'h0000_0001_0000_0000);
        send_cmd(MODE_RESEED, 64'd0);
        send_cmd(MODE_DRAW, 64'h0000_0003_FFFF_FFFF);
        drain();
        write_seed(64'd0);
        send_cmd(MODE_RESEED, 64'd0);
        send_cmd(MODE_DRAW, 64'd6);

        // Random segments, each opened on an idle block, some without gaps
        while (cmds_sent < TOTAL_CMDS) begin
            drain();
            if ($urandom_range(0, 2) == 0)
                write_seed(rand_seed());
            no_gaps = ($urandom_range(0, 3) == 0);
            seg_len = $urandom_range(40, 120);
            for (int i = 0; i < seg_len && cmds_sent < TOTAL_CMDS; i++) begin
                mode = MODE_DRAW;
                if ($urandom_range(0, 99) == 0 || (i == 0 && $urandom_range(0, 1) == 1))
                    mode = MODE_RESEED;
                send_cmd(mode, rand_bound());
            end
        end
        no_gaps = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mtrb_pkg.sv
design/mtrb_ram.sv
design/mtrb_front.sv
design/mtrb_queue.sv
design/mtrb_back.sv
design/mt19937_rand_below_top.sv
sim/mtrb_checker.sv
sim/tb.sv
